// ===== design/dvpw_pkg.sv =====
package dvpw_pkg;

  localparam int VOICES    = 4;
  localparam int WORD_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int VOICE_W   = 3;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int BIT_CNT_W = $clog2(WORD_BITS);
  localparam int DIV_CNT_W = $clog2(DATA_W);

  localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_PULSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_PHASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_VOICE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DUTY_HIGH = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON_CYCLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY      = 2'd2;

  typedef enum logic [2:0] {
    VOP_IDLE,
    VOP_STEP,
    VOP_PULSE,
    VOP_SUB_OFF,
    VOP_ADD_OFF,
    VOP_STOP
  } voice_op_e;

  typedef struct packed {
    voice_op_e            op;
    logic [VOICE_W-1:0]   voice;
    logic [DATA_W-1:0]    tw;
    logic [DATA_W-1:0]    duty;
    logic [DATA_W-1:0]    off;
  } voice_ctrl_t;

endpackage

// ===== design/dvpw_voice.sv =====
module dvpw_voice (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dvpw_pkg::VOICE_W-1:0] lane_i,
  input  dvpw_pkg::voice_ctrl_t        ctrl_i,
  output logic                         hit_o
);
  import dvpw_pkg::*;

  logic [DATA_W-1:0] phase_q, phase_d;
  logic [DATA_W-1:0] tw_q, tw_d;
  logic [DATA_W-1:0] duty_q, duty_d;
  logic [DATA_W-1:0] off_q, off_d;
  logic [DATA_W-1:0] next_phase;
  logic              sel;

  assign sel        = (ctrl_i.voice == lane_i);
  assign next_phase = phase_q + tw_q;
  assign hit_o      = (next_phase < duty_q);

  always_comb begin
    phase_d = phase_q;
    tw_d    = tw_q;
    duty_d  = duty_q;
    off_d   = off_q;
    case (ctrl_i.op)
      VOP_STEP: begin
        phase_d = next_phase;
      end
      VOP_PULSE: begin
        if (sel) begin
          tw_d   = ctrl_i.tw;
          duty_d = ctrl_i.duty;
        end
      end
      VOP_SUB_OFF: begin
        if (sel) begin
          phase_d = phase_q - off_q;
        end
      end
      VOP_ADD_OFF: begin
        if (sel) begin
          phase_d = phase_q + ctrl_i.off;
          off_d   = ctrl_i.off;
        end
      end
      VOP_STOP: begin
        duty_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      tw_q    <= '0;
      duty_q  <= '0;
      off_q   <= '0;
    end else begin
      phase_q <= phase_d;
      tw_q    <= tw_d;
      duty_q  <= duty_d;
      off_q   <= off_d;
    end
  end

endmodule

// ===== design/dvpw_div.sv =====
module dvpw_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dvpw_pkg::DATA_W-1:0] dividend_i,
  input  logic [dvpw_pkg::DATA_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [dvpw_pkg::DATA_W-1:0] quot_o
);
  import dvpw_pkg::*;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DATA_W - 1);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    dvs_q, dvs_d;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = !rem_sub[DATA_W];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (run_q) begin
      rem_d = fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== design/multi_voice_dds_pulse_word_generator.sv =====
// Tick: one output bit per cycle; the word is decoded and its bits are shifted in. Set pulse:
// decoded and checked; the bit-serial on-time divider runs before the result when the voice
// is valid and the duty and tuning words are nonzero. Set phase: the voice subtracts its old
// offset, then adds the new one; stop: decoded, all duties cleared. One word in work at a time.
// Each result enters the output register once the output is free. Reset (async, active low)
// clears all voice state, config registers and handshake state, but not the data registers.
module multi_voice_dds_pulse_word_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dvpw_pkg::CMD_W-1:0]      cmd_i,
  input  logic [dvpw_pkg::VOICE_W-1:0]    voice_i,
  input  logic [dvpw_pkg::DATA_W-1:0]     tuning_word_i,
  input  logic [dvpw_pkg::DATA_W-1:0]     duty_word_i,
  input  logic [dvpw_pkg::DATA_W-1:0]     phase_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dvpw_pkg::DATA_W-1:0]     sample_word_o,
  output logic [dvpw_pkg::STATUS_W-1:0]   status_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dvpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dvpw_pkg::DATA_W-1:0]     cfg_data_i
);
  import dvpw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PH2  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_BITS - 1);

  logic [2:0]           state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [VOICE_W-1:0]   voice_q, voice_d;
  logic [DATA_W-1:0]    tw_q, tw_d;
  logic [DATA_W-1:0]    duty_q, duty_d;
  logic [DATA_W-1:0]    off_q, off_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [STATUS_W-1:0]  res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_word_q, out_word_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic                 active_low_q;
  logic [DATA_W-1:0]    max_on_q;
  logic [DATA_W-1:0]    max_duty_q;

  logic                 in_acc;
  logic                 bad_voice;
  logic                 out_free;
  logic                 div_start;
  logic                 div_done;
  logic [DATA_W-1:0]    div_quot;
  logic [VOICES-1:0]    hits;
  logic                 tick_bit;
  voice_ctrl_t          vctrl;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign bad_voice   = (int'(voice_q) >= VOICES);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign tick_bit    = active_low_q ^ (^hits);

  for (genvar g = 0; g < VOICES; g++) begin : g_voice
    dvpw_voice u_voice (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (VOICE_W'(g)),
      .ctrl_i (vctrl),
      .hit_o  (hits[g])
    );
  end

  dvpw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (duty_q),
    .divisor_i  (tw_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    bit_cnt_d    = bit_cnt_q;
    cmd_d        = cmd_q;
    voice_d      = voice_q;
    tw_d         = tw_q;
    duty_d       = duty_q;
    off_d        = off_q;
    word_d       = word_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    div_start    = 1'b0;
    vctrl.op     = VOP_IDLE;
    vctrl.voice  = voice_q;
    vctrl.tw     = tw_q;
    vctrl.duty   = duty_q;
    vctrl.off    = off_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_i;
          voice_d = voice_i;
          tw_d    = tuning_word_i;
          duty_d  = duty_word_i;
          off_d   = phase_offset_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        word_d       = '0;
        bit_cnt_d    = '0;
        res_status_d = ST_OK;
        state_d      = S_DONE;
        case (cmd_q)
          CMD_TICK: begin
            state_d = S_TICK;
          end
          CMD_SET_PULSE: begin
            if (bad_voice) begin
              res_status_d = ST_BAD_VOICE;
            end else if (duty_q != '0 && tw_q == '0) begin
              res_status_d = ST_TOO_LONG;
            end else if (duty_q != '0) begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end else if (duty_q > max_duty_q) begin
              res_status_d = ST_DUTY_HIGH;
            end else begin
              vctrl.op = VOP_PULSE;
            end
          end
          CMD_SET_PHASE: begin
            if (bad_voice) begin
              res_status_d = ST_BAD_VOICE;
            end else begin
              vctrl.op = VOP_SUB_OFF;
              state_d  = S_PH2;
            end
          end
          default: begin
            vctrl.op = VOP_STOP;
          end
        endcase
      end
      S_TICK: begin
        vctrl.op  = VOP_STEP;
        word_d    = {word_q[WORD_BITS-2:0], tick_bit};
        bit_cnt_d = bit_cnt_q + 1'b1;
        if (bit_cnt_q == LAST_BIT) begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
          if (div_quot > max_on_q) begin
            res_status_d = ST_TOO_LONG;
          end else if (duty_q > max_duty_q) begin
            res_status_d = ST_DUTY_HIGH;
          end else begin
            vctrl.op = VOP_PULSE;
          end
        end
      end
      S_PH2: begin
        vctrl.op = VOP_ADD_OFF;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = DATA_W'(word_q);
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      active_low_q <= 1'b0;
      max_on_q     <= '0;
      max_duty_q   <= '0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ACTIVE_LOW:    active_low_q <= cfg_data_i[0];
          CFG_MAX_ON_CYCLES: max_on_q     <= cfg_data_i;
          CFG_MAX_DUTY:      max_duty_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    voice_q      <= voice_d;
    tw_q         <= tw_d;
    duty_q       <= duty_d;
    off_q        <= off_d;
    word_q       <= word_d;
    res_status_q <= res_status_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign sample_word_o = out_word_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside of the check state");

  a_tick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK) |-> (cmd_q == CMD_TICK))
    else $error("word generation without a tick command");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_word_q == '0))
    else $error("rejected command carries a nonzero word");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside of the done state");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import dvpw_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [VOICE_W-1:0]  voice;
    logic [DATA_W-1:0]   tw;
    logic [DATA_W-1:0]   duty;
    logic [DATA_W-1:0]   ph;
    logic                typed;
    logic [DATA_W-1:0]   word;
    logic [STATUS_W-1:0] st;
  } stim_row_t;

  typedef struct packed {
    logic [DATA_W-1:0]   word;
    logic [STATUS_W-1:0] st;
  } pulse_result_t;

  localparam int N_DIRECTED = 22;
  localparam int SEG_ITEMS  = 163;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{CMD_TICK,      3'd0, 32'h0,         32'h0,         32'h0,         1'b1, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd5, 32'h1,         32'h0,         32'h0,         1'b1, 32'h0, ST_BAD_VOICE},
    '{CMD_SET_PHASE, 3'd7, 32'h0,         32'h0,         32'hFFFF_FFFF, 1'b1, 32'h0, ST_BAD_VOICE},
    '{CMD_SET_PULSE, 3'd0, 32'h0,         32'h1,         32'h0,         1'b1, 32'h0, ST_TOO_LONG},
    '{CMD_SET_PULSE, 3'd0, 32'h1,         32'h5,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd1, 32'hFFFF_FFFF, 32'h0,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_TICK,      3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd0, 32'h0800_0000, 32'h8000_0000, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PHASE, 3'd3, 32'h0,         32'h0,         32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
    '{CMD_SET_PHASE, 3'd0, 32'h0,         32'h0,         32'h4000_0000, 1'b0, 32'h0, ST_OK},
    '{CMD_TICK,      3'd0, 32'h0,         32'h0,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_TICK,      3'd7, 32'h0,         32'h0,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_STOP,      3'd2, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0,         1'b1, 32'h0, ST_OK},
    '{CMD_TICK,      3'd0, 32'h0,         32'h0,         32'h0,         1'b1, 32'hFFFF_FFFF, ST_OK},
    '{CMD_SET_PULSE, 3'd2, 32'h0100_0000, 32'h0400_0000, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd2, 32'h0100_0000, 32'h2000_0000, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd2, 32'h1000_0000, 32'h2000_0000, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd2, 32'h0800_0000, 32'h1000_0000, 32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_TICK,      3'd1, 32'h0,         32'h0,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_SET_PULSE, 3'd1, 32'h0,         32'h0,         32'h0,         1'b0, 32'h0, ST_OK},
    '{CMD_TICK,      3'd0, 32'h0,         32'h0,         32'h0,         1'b0, 32'h0, ST_OK}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     cmd           = CMD_TICK;
  logic [VOICE_W-1:0]   voice         = '0;
  logic [DATA_W-1:0]    tuning_word   = '0;
  logic [DATA_W-1:0]    duty_word     = '0;
  logic [DATA_W-1:0]    phase_offset  = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [DATA_W-1:0]    sample_word;
  logic [STATUS_W-1:0]  status;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_ACTIVE_LOW;
  logic [DATA_W-1:0]    cfg_data      = '0;

  logic [DATA_W-1:0] acc_st  [VOICES];
  logic [DATA_W-1:0] tw_st   [VOICES];
  logic [DATA_W-1:0] duty_st [VOICES];
  logic [DATA_W-1:0] off_st  [VOICES];
  logic              lvl_inv;
  logic [DATA_W-1:0] lim_on;
  logic [DATA_W-1:0] lim_duty;

  pulse_result_t pending_words [$];
  pulse_result_t want;

  int snd_idle  = 0;
  int rcv_stall = 0;
  int err_count = 0;
  int n_items   = 0;
  int n_ticks   = 0;
  int n_rejects = 0;
  int n_cfg     = 0;

  always #1 clk_i = ~clk_i;

  multi_voice_dds_pulse_word_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .voice_i       (voice),
    .tuning_word_i (tuning_word),
    .duty_word_i   (duty_word),
    .phase_offset_i(phase_offset),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .sample_word_o (sample_word),
    .status_o      (status),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_val);
    err_count++;
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, exp_val, $realtime);
  endtask

  function automatic pulse_result_t step_voices(input stim_row_t r);
    pulse_result_t res;
    logic [DATA_W-1:0] phase;
    logic b;
    res.word = '0;
    res.st = ST_OK;
    case (r.cmd)
      CMD_TICK: begin
        for (int i = 0; i < WORD_BITS; i++) begin
          b = lvl_inv;
          for (int v = 0; v < VOICES; v++) begin
            acc_st[v] = acc_st[v] + tw_st[v];
            phase = acc_st[v] + off_st[v];
            if (phase < duty_st[v]) b = ~b;
          end
          res.word = {res.word[DATA_W-2:0], b};
        end
      end
      CMD_SET_PULSE: begin
        if (r.voice >= VOICES) begin
          res.st = ST_BAD_VOICE;
        end else if (r.duty != '0 && r.tw == '0) begin
          res.st = ST_TOO_LONG;
        end else if (r.duty != '0 && (r.duty / r.tw) > lim_on) begin
          res.st = ST_TOO_LONG;
        end else if (r.duty > lim_duty) begin
          res.st = ST_DUTY_HIGH;
        end else begin
          tw_st[r.voice[1:0]]   = r.tw;
          duty_st[r.voice[1:0]] = r.duty;
        end
      end
      CMD_SET_PHASE: begin
        if (r.voice >= VOICES) res.st = ST_BAD_VOICE;
        else off_st[r.voice[1:0]] = r.ph;
      end
      default: begin
        for (int v = 0; v < VOICES; v++) duty_st[v] = '0;
      end
    endcase
    return res;
  endfunction

  task automatic send_item(input stim_row_t r);
    pulse_result_t res;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    cmd          <= r.cmd;
    voice        <= r.voice;
    tuning_word  <= r.tw;
    duty_word    <= r.duty;
    phase_offset <= r.ph;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    res = step_voices(r);
    if (r.typed) begin
      res.word = r.word;
      res.st   = r.st;
    end
    pending_words.push_back(res);
    n_items++;
    if (r.cmd == CMD_TICK) n_ticks++;
    if (res.st != ST_OK) n_rejects++;
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      CFG_ACTIVE_LOW:    lvl_inv  = val[0];
      CFG_MAX_ON_CYCLES: lim_on   = val;
      CFG_MAX_DUTY:      lim_duty = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic apply_limits(input logic inv, input logic [DATA_W-1:0] on_lim,
                              input logic [DATA_W-1:0] duty_lim);
    logic [DATA_W-1:0] inv_word;
    inv_word = $urandom;
    inv_word[0] = inv;
    drain_words();
    write_reg(CFG_ACTIVE_LOW, inv_word);
    write_reg(CFG_MAX_ON_CYCLES, on_lim);
    write_reg(CFG_MAX_DUTY, duty_lim);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1, 2:    return '1;
      3:       return $urandom_range(100);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    logic [DATA_W-1:0] k;
    int sel;
    r       = '0;
    r.voice = VOICE_W'($urandom);
    r.tw    = $urandom;
    r.duty  = $urandom;
    r.ph    = $urandom;
    sel     = $urandom_range(99);
    if (sel < 45) r.cmd = CMD_TICK;
    else if (sel < 80) r.cmd = CMD_SET_PULSE;
    else if (sel < 95) r.cmd = CMD_SET_PHASE;
    else r.cmd = CMD_STOP;
    if ($urandom_range(99) < 85) r.voice = VOICE_W'($urandom_range(VOICES - 1));
    if (r.cmd == CMD_SET_PULSE) begin
      case ($urandom_range(9))
        0:       r.duty = '0;
        1:       r.duty = '1;
        2:       r.tw = '0;
        3, 4:    r.tw = r.tw >> $urandom_range(31);
        default: begin
          r.duty = $urandom_range(lim_duty);
          k      = $urandom_range(64, 1);
          r.tw   = r.duty / k + 1;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with no expectation", sample_word, '0);
      end else begin
        want = pending_words.pop_front();
        if (sample_word !== want.word) report_mismatch("sample_word", sample_word, want.word);
        if (status !== want.st) begin
          report_mismatch("status", DATA_W'(status), DATA_W'(want.st));
        end
      end
    end
    out_stall <= ($urandom_range(99) < rcv_stall);
  end

  initial begin
    for (int v = 0; v < VOICES; v++) begin
      acc_st[v]  = '0;
      tw_st[v]   = '0;
      duty_st[v] = '0;
      off_st[v]  = '0;
    end
    lvl_inv  = 1'b0;
    lim_on   = '0;
    lim_duty = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == 7) apply_limits(1'b1, '1, '1);
      if (i == 15) apply_limits(1'b0, 32'd3, 32'h1000_0000);
      send_item(DIRECTED[i]);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin snd_idle = 0;  rcv_stall = 0;  end
        1:       begin snd_idle = 61; rcv_stall = 0;  end
        2:       begin snd_idle = 0;  rcv_stall = 61; end
        default: begin snd_idle = 11; rcv_stall = 11; end
      endcase
      for (int s = 0; s < 2; s++) begin
        apply_limits(1'($urandom_range(1)), pick_limit(), pick_limit());
        for (int n = 0; n < SEG_ITEMS; n++) send_item(rand_row());
      end
    end

    drain_words();
    $display("Covered %0d words: %0d ticks, %0d rejected settings, %0d register writes",
             n_items, n_ticks, n_rejects, n_cfg);
    $display("Idle and stall mixes: none, sender 61%%, receiver 61%%, both 11%%");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d words outstanding", pending_words.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
